// ----- hdl/lru_key_value_cache_core_assert.svh -----
// assertion macros shared by the cache rtl
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// implication checked in the cycle after the antecedent, disabled in reset
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// same-cycle implication, disabled in reset
`define LKVC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lkvc_pkg.sv -----
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE     = '1;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic             load;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

// ----- hdl/lkvc_cell.sv -----
module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  t_entry           i_shift,
    input  logic             i_hit_up,
    input  logic [VAL_W-1:0] i_val_up,
    output t_entry           o_entry,
    output logic             o_hit_up,
    output logic [VAL_W-1:0] o_val_up
);

    t_entry r_entry;
    logic   hit;

    assign hit      = r_entry.valid && (r_entry.key == i_ctl.key);
    assign o_hit_up = hit | i_hit_up;
    assign o_val_up = (hit ? r_entry.value : '0) | i_val_up;
    assign o_entry  = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_entry.valid <= i_shift.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry.key   <= i_shift.key;
            r_entry.value <= i_shift.value;
        end
    end

endmodule

// ----- hdl/lru_key_value_cache_core.sv -----
// a get result strobes in the cycle after the work cycle
// a new item is accepted only while not busy; busy covers the compare-and-shift work cycle
// a put gives no result; the receiver cannot stall the result strobe
// reset (synchronous, active low) empties every cell and sets capacity to 16
// store is cleared at once by per-cell valid bits, no clearing pass
`include "lru_key_value_cache_core_assert.svh"

module lru_key_value_cache_core
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_req_type,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_result_valid,
    output logic                    o_found,
    output logic signed [VAL_W-1:0] o_read_value,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic        [CAP_W-1:0] i_cfg_data
);

    // occupancy holds 0..ENTRIES
    localparam int OW = $clog2(ENTRIES + 1);
    // common width for the capacity / occupancy compare
    localparam int CW = (OW > CAP_W) ? OW : CAP_W;

    // request register, loaded when an item is accepted
    logic             r_busy;
    logic             r_req;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;

    logic [CAP_W-1:0] r_capacity;
    logic [OW-1:0]    r_occ;
    logic [OW-1:0]    n_occ;

    logic             r_result_valid;
    logic             r_found;
    logic [VAL_W-1:0] r_read_value;

    // cell row: cell 0 is most recent, recency rank is the cell position
    t_entry           cell_entry [ENTRIES];
    t_cell_ctl        cell_ctl   [ENTRIES];
    t_entry           cell_shift [ENTRIES];
    logic             hit_up     [ENTRIES+1];
    logic [VAL_W-1:0] val_up     [ENTRIES+1];
    logic [ENTRIES-1:0] valid_vec;

    logic             accept;
    logic             hit_any;
    logic             full;
    logic [CW-1:0]    eff_cap;
    logic [OW-1:0]    limit;
    t_entry           front;

    assign accept      = start && !busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    // top of the hit / value chains
    assign hit_up[ENTRIES] = 1'b0;
    assign val_up[ENTRIES] = '0;
    assign hit_any         = hit_up[0];

    // capacity 0 acts as 1, above ENTRIES acts as ENTRIES
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CW'(1);
        end else if (CW'(r_capacity) > CW'(ENTRIES)) begin
            eff_cap = CW'(ENTRIES);
        end else begin
            eff_cap = CW'(r_capacity);
        end
    end

    assign full = CW'(r_occ) >= eff_cap;

    // on a put miss: new key enters at the front, the row shifts up to the
    // first empty cell, or up to the least recent cell when full
    assign limit = full ? (r_occ - OW'(1)) : r_occ;

    // entry that lands in cell 0
    always_comb begin
        front.valid = 1'b1;
        front.key   = r_key;
        if (hit_any && (r_req == REQ_GET)) begin
            front.value = val_up[0];
        end else begin
            front.value = r_value;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            // on a hit, cells at or below the hit cell move up one
            // a get miss leaves the row untouched
            assign cell_ctl[gi].load = r_busy &&
                (hit_any ? hit_up[gi] : ((r_req == REQ_PUT) && (OW'(gi) <= limit)));
            assign cell_ctl[gi].key  = r_key;
            assign valid_vec[gi]     = cell_entry[gi].valid;

            if (gi == 0) begin : g_head
                assign cell_shift[gi] = front;
            end else begin : g_body
                assign cell_shift[gi] = cell_entry[gi-1];
            end

            lkvc_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (cell_ctl[gi]),
                .i_shift  (cell_shift[gi]),
                .i_hit_up (hit_up[gi+1]),
                .i_val_up (val_up[gi+1]),
                .o_entry  (cell_entry[gi]),
                .o_hit_up (hit_up[gi]),
                .o_val_up (val_up[gi])
            );
        end
    endgenerate

    // occupancy grows only on an insert into a free cell
    always_comb begin
        n_occ = r_occ;
        if (r_busy && (r_req == REQ_PUT) && !hit_any && !full) begin
            n_occ = r_occ + OW'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_occ          <= '0;
            r_capacity     <= CAPACITY_RESET;
            r_result_valid <= 1'b0;
        end else begin
            r_busy         <= accept;
            r_occ          <= n_occ;
            r_result_valid <= r_busy && (r_req == REQ_GET);
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_req_type;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (r_busy) begin
            r_found      <= hit_any;
            r_read_value <= hit_any ? val_up[0] : MISS_VALUE;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_found        = r_found;
    assign o_read_value   = r_read_value;

    // every item finishes in its work cycle, busy is never held
    `LKVC_ASSERT_NEXT(a_busy_one_cycle, r_busy, !r_busy, "busy held past one cycle")
    // an accepted get strobes a result after its work cycle
    `LKVC_ASSERT_NEXT(a_get_result, r_busy && (r_req == REQ_GET), o_result_valid, "get gave no result")
    // filled cells stay packed at the low end and match the occupancy count
    `LKVC_ASSERT_NOW(a_occ_count, 1'b1, (OW'($countones(valid_vec)) == r_occ) && ((valid_vec & (valid_vec + ENTRIES'(1))) == '0), "cell row not packed")
    // a miss reports the miss value
    `LKVC_ASSERT_NOW(a_miss_value, o_result_valid && !o_found, o_read_value == MISS_VALUE, "miss value wrong")

endmodule
